FILE: hdl/ram_bank_window_mapper_macros.svh
// Assertion macros for the ram_bank_window_mapper block.
// They expect clk and rst_n (synchronous, active low) in the including scope.
`ifndef RAM_BANK_WINDOW_MAPPER_MACROS_SVH
`define RAM_BANK_WINDOW_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbw assertion failed");

`endif

FILE: hdl/rbw_pkg.sv
// Shared types and constants of the RAM bank / window mapper.
// No dependencies; imported by every module of the block.
package rbw_pkg;

  localparam int EXT_BANKS  = 4;                        // 1 .. 16 extension banks
  localparam int BANK_AW    = 15;                       // 32 KiB per bank
  localparam int MAIN_AW    = 16;                       // 64 KiB main RAM
  localparam int MAIN_DEPTH = 1 << MAIN_AW;
  localparam int EXT_DEPTH  = EXT_BANKS * (1 << BANK_AW);
  localparam int EXT_AW     = $clog2(EXT_DEPTH);
  localparam int CLR_DEPTH  = (EXT_DEPTH > MAIN_DEPTH) ? EXT_DEPTH : MAIN_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  typedef enum logic [1:0] {
    CMD_MEM_READ   = 2'd0,
    CMD_MEM_WRITE  = 2'd1,
    CMD_PORT_WRITE = 2'd2,
    CMD_CPU_RESET  = 2'd3
  } command_t;

  localparam logic [7:0] PORT_RAM_MODE  = 8'h31;
  localparam logic [7:0] PORT_WIN_BASE  = 8'h70;
  localparam logic [7:0] PORT_WIN_STEP  = 8'h78;
  localparam logic [7:0] PORT_BANK_CTRL = 8'he2;
  localparam logic [7:0] PORT_BANK_NUM  = 8'he3;

  localparam int BANK_RD_EN_BIT = 0;
  localparam int BANK_WR_EN_BIT = 4;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // write zero at the clear counter, advance it
    logic accept;    // take the input transaction
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

FILE: hdl/rbw_in_if.sv
// Input channel of the mapper: valid/ready handshake plus one bus access.
// Depends on nothing.
interface rbw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] mem_address;
  logic [7:0]  port_number;
  logic [7:0]  write_data;

  modport source (output valid, command, mem_address, port_number, write_data, input ready);
  modport sink   (input valid, command, mem_address, port_number, write_data, output ready);
endinterface

FILE: hdl/rbw_out_if.sv
// Result channel of the mapper: valid/ready handshake plus one result.
// Depends on nothing.
interface rbw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       pass_through;
  logic       forward_write;

  modport source (output valid, read_data, pass_through, forward_write, input ready);
  modport sink   (input valid, read_data, pass_through, forward_write, output ready);
endinterface

FILE: hdl/ram_bank_window_mapper.sv
// Top level of the RAM bank / window mapper.
// Depends on rbw_pkg, rbw_in_if, rbw_out_if, rbw_ctrl, rbw_datapath and the macros header.
//
// Usage:
//   in_ch  carries one bus access per transaction: memory read, memory write,
//          port write or CPU reset. out_ch returns exactly one result per access:
//          read byte, ROM pass-through flag and write-forward flag.
//   The RAM read is registered into the read stage at the edge that accepts the
//   access; the result then enters the output register, and out_ch.valid rises,
//   once out_ch is free.
//   A new transaction is taken only after the previous result has moved on;
//   in_ch.ready is low in the cycle that moves the result into the output register.
//   Reset: rst_n clears the port registers and starts a clearing pass that
//   zeroes both RAM arrays one entry per cycle over CLR_DEPTH entries
//   (131072 with four extension banks). in_ch.ready stays low until it ends.
//   Stall: while out_ch holds an untaken result, one further access is taken
//   and kept in the read stage; in_ch then waits until out_ch.ready frees
//   the output register.
`include "ram_bank_window_mapper_macros.svh"

module ram_bank_window_mapper
  import rbw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  rbw_in_if.sink     in_ch,
  rbw_out_if.source  out_ch
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rbw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  rbw_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .command       (in_ch.command),
    .mem_address   (in_ch.mem_address),
    .port_number   (in_ch.port_number),
    .write_data    (in_ch.write_data),
    .read_data     (out_ch.read_data),
    .pass_through  (out_ch.pass_through),
    .forward_write (out_ch.forward_write)
  );

  // no transaction is taken during the clearing pass
  `RBW_ASSERT_IMPL(a_no_accept_in_clear, in_ch.ready, !dp_cmd.clear)
  // a result only appears after a load of the output register
  `RBW_ASSERT_IMPL(a_out_from_load, $rose(out_ch.valid), $past(dp_cmd.load_out))
  // an accepted transaction blocks the input until its result is loaded
  `RBW_ASSERT_NEXT(a_accept_blocks, dp_cmd.accept, !in_ch.ready)

endmodule

FILE: hdl/rbw_ctrl.sv
// Controller of the mapper: clearing pass, accept, result hand-off.
// Depends on rbw_pkg.
module rbw_ctrl
  import rbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.clear    = (state_r == S_CLEAR);
  assign cmd.accept   = in_valid && (state_r == S_IDLE);
  assign cmd.load_out = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (status.clear_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          // hold the read result until the output register is free
          if (cmd.load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/rbw_datapath.sv
// Datapath of the mapper: main and extension RAM, port registers,
// address decode and the output register. Depends on rbw_pkg.
module rbw_datapath
  import rbw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [1:0]  command,
  input  logic [15:0] mem_address,
  input  logic [7:0]  port_number,
  input  logic [7:0]  write_data,
  output logic [7:0]  read_data,
  output logic        pass_through,
  output logic        forward_write
);

  logic [7:0] main_ram [MAIN_DEPTH];
  logic [7:0] ext_ram  [EXT_DEPTH];

  logic [CLR_W-1:0] clr_cnt_r;
  logic [1:0]       ram_mode_r,     ram_mode_nxt;
  logic [7:0]       win_base_r,     win_base_nxt;
  logic [7:0]       bank_ctrl_r,    bank_ctrl_nxt;
  logic [7:0]       bank_num_r,     bank_num_nxt;

  logic [7:0] main_q_r, ext_q_r;
  logic       sel_ext_r, sel_main_r, pass_r, fwd_r;
  logic [7:0] read_data_r;
  logic       pass_out_r, fwd_out_r;

  command_t         cmd_code;
  logic             is_read, is_write, is_port;
  logic             low_area, bank_ok, rd_ext, wr_ext;
  logic [BANK_AW-1:0] offset;
  logic [MAIN_AW-1:0] win_idx, main_addr;
  logic [EXT_AW-1:0]  ext_addr;
  logic             main_clr_en, ext_clr_en;
  logic             main_we, ext_we;
  logic [MAIN_AW-1:0] main_waddr;
  logic [EXT_AW-1:0]  ext_waddr;
  logic [7:0]       wdata;

  assign cmd_code = command_t'(command);
  assign is_read  = (cmd_code == CMD_MEM_READ);
  assign is_write = (cmd_code == CMD_MEM_WRITE);
  assign is_port  = (cmd_code == CMD_PORT_WRITE);

  assign low_area = !mem_address[15];
  assign offset   = mem_address[BANK_AW-1:0];
  assign win_idx  = {win_base_r, 8'h00} + {6'b0, mem_address[9:0]};
  assign bank_ok  = (bank_num_r < 8'(EXT_BANKS));
  assign rd_ext   = low_area && bank_ctrl_r[BANK_RD_EN_BIT] && bank_ok;
  assign wr_ext   = low_area && bank_ctrl_r[BANK_WR_EN_BIT] && bank_ok;
  assign main_addr = low_area ? {1'b0, offset} : win_idx;
  assign ext_addr  = EXT_AW'({bank_num_r, offset});

  // clearing pass: both memories swept together from the same counter
  assign main_clr_en = cmd.clear && (CLR_W'(clr_cnt_r >> MAIN_AW) == '0);
  assign ext_clr_en  = cmd.clear && ({1'b0, clr_cnt_r} < (CLR_W+1)'(EXT_DEPTH));
  assign status.clear_last = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));

  assign main_we    = main_clr_en || (cmd.accept && is_write && !wr_ext);
  assign ext_we     = ext_clr_en  || (cmd.accept && is_write && wr_ext);
  assign main_waddr = cmd.clear ? clr_cnt_r[MAIN_AW-1:0] : main_addr;
  assign ext_waddr  = cmd.clear ? clr_cnt_r[EXT_AW-1:0]  : ext_addr;
  assign wdata      = cmd.clear ? 8'h00 : write_data;

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_ram[main_waddr] <= wdata;
    end
    if (cmd.accept && is_read) begin
      main_q_r <= main_ram[main_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_ram[ext_waddr] <= wdata;
    end
    if (cmd.accept && is_read && rd_ext) begin
      ext_q_r <= ext_ram[ext_addr];
    end
  end

  // port registers
  always_comb begin
    ram_mode_nxt  = ram_mode_r;
    win_base_nxt  = win_base_r;
    bank_ctrl_nxt = bank_ctrl_r;
    bank_num_nxt  = bank_num_r;
    if (cmd.accept && is_port) begin
      unique case (port_number)
        PORT_RAM_MODE:  ram_mode_nxt  = write_data[2:1];
        PORT_WIN_BASE:  win_base_nxt  = write_data;
        PORT_WIN_STEP:  win_base_nxt  = win_base_r + 8'd1;
        PORT_BANK_CTRL: bank_ctrl_nxt = write_data;
        PORT_BANK_NUM:  bank_num_nxt  = write_data;
        default: ;
      endcase
    end else if (cmd.accept && (cmd_code == CMD_CPU_RESET)) begin
      // window base survives a CPU reset
      ram_mode_nxt  = '0;
      bank_ctrl_nxt = '0;
      bank_num_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      ram_mode_r  <= '0;
      win_base_r  <= '0;
      bank_ctrl_r <= '0;
      bank_num_r  <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      ram_mode_r  <= ram_mode_nxt;
      win_base_r  <= win_base_nxt;
      bank_ctrl_r <= bank_ctrl_nxt;
      bank_num_r  <= bank_num_nxt;
    end
  end

  // result of the accepted transaction, completed once the RAM data is back
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sel_ext_r  <= is_read && rd_ext;
      sel_main_r <= is_read && (!low_area || (!rd_ext && ram_mode_r[0]));
      pass_r     <= is_read && low_area && !rd_ext && !ram_mode_r[0];
      fwd_r      <= is_write;
    end
    if (cmd.load_out) begin
      priority if (sel_ext_r) begin
        read_data_r <= ext_q_r;
      end else if (sel_main_r) begin
        read_data_r <= main_q_r;
      end else begin
        read_data_r <= 8'h00;
      end
      pass_out_r <= pass_r;
      fwd_out_r  <= fwd_r;
    end
  end

  assign read_data     = read_data_r;
  assign pass_through  = pass_out_r;
  assign forward_write = fwd_out_r;

endmodule

FILE: dv/tb_ram_bank_window_mapper.sv
// Self-checking testbench of ram_bank_window_mapper: directed and random bus accesses.
// Mirrors the RAM arrays and port registers to predict every result.
// Depends on rbw_pkg, rbw_in_if, rbw_out_if and the mapper RTL.
module tb_ram_bank_window_mapper
  import rbw_pkg::*;
();

  localparam int STALL_LIMIT = 4 * CLR_DEPTH;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pass_through;
    logic       forward_write;
  } mapper_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rbw_in_if  in_if();
  rbw_out_if out_if();

  ram_bank_window_mapper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #1 clk = ~clk;

  // Shadow copy of the mapper state
  bit [7:0] main_mem [MAIN_DEPTH];
  bit [7:0] ext_mem [EXT_DEPTH];
  bit [1:0] ram_mode_q;
  bit [7:0] win_base_q;
  bit [7:0] bank_ctrl_q;
  bit [7:0] bank_num_q;

  mapper_result_t pending_results[$];
  int unsigned    fail_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_request;
  int unsigned    hold_left;
  int unsigned    quiet_cycles;
  logic [15:0]    hot_addr [8];

  function automatic mapper_result_t map_bus_access(command_t cmd, logic [15:0] addr,
                                                    logic [7:0] port, logic [7:0] data);
    mapper_result_t res;
    logic [15:0]    win_idx;
    int unsigned    ext_idx;
    logic           bank_ok;
    res = '0;
    win_idx = {6'd0, addr[9:0]} + {win_base_q, 8'd0};
    ext_idx = int'(bank_num_q) * (1 << BANK_AW) + int'(addr[14:0]);
    bank_ok = int'(bank_num_q) < EXT_BANKS;
    case (cmd)
      CMD_MEM_READ: begin
        if (addr[15]) begin
          res.read_data = main_mem[win_idx];
        end else if (bank_ctrl_q[BANK_RD_EN_BIT] && bank_ok) begin
          res.read_data = ext_mem[ext_idx];
        end else if (ram_mode_q[0]) begin
          res.read_data = main_mem[addr[14:0]];
        end else begin
          res.pass_through = 1'b1;
        end
      end
      CMD_MEM_WRITE: begin
        if (addr[15]) begin
          main_mem[win_idx] = data;
        end else if (bank_ctrl_q[BANK_WR_EN_BIT] && bank_ok) begin
          ext_mem[ext_idx] = data;
        end else begin
          main_mem[addr[14:0]] = data;
        end
        res.forward_write = 1'b1;
      end
      CMD_PORT_WRITE: begin
        case (port)
          PORT_RAM_MODE:  ram_mode_q = data[2:1];
          PORT_WIN_BASE:  win_base_q = data;
          PORT_WIN_STEP:  win_base_q = win_base_q + 8'd1;
          PORT_BANK_CTRL: bank_ctrl_q = data;
          PORT_BANK_NUM:  bank_num_q = data;
          default: ;
        endcase
      end
      default: begin
        ram_mode_q = '0;
        bank_ctrl_q = '0;
        bank_num_q = '0;
      end
    endcase
    return res;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_access(command_t cmd, logic [15:0] addr, logic [7:0] port,
                             logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.mem_address <= addr;
    in_if.port_number <= port;
    in_if.write_data  <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(map_bus_access(cmd, addr, port, data));
    @(negedge clk);
  endtask

  task automatic send_random_access();
    command_t    cmd;
    logic [15:0] addr;
    logic [7:0]  port;
    logic [7:0]  data;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CMD_MEM_READ;
    else if (pick < 75) cmd = CMD_MEM_WRITE;
    else if (pick < 95) cmd = CMD_PORT_WRITE;
    else cmd = CMD_CPU_RESET;
    // Reuse a few hot addresses so reads find earlier writes
    pick = $urandom_range(99);
    if (pick < 60) addr = hot_addr[$urandom_range(7)];
    else if (pick < 95) addr = 16'($urandom_range(16'h83ff));
    else addr = 16'($urandom_range(16'hffff));
    data = 8'($urandom_range(255));
    port = 8'($urandom_range(255));
    if (cmd == CMD_PORT_WRITE) begin
      case ($urandom_range(9))
        0, 1: port = PORT_RAM_MODE;
        2: port = PORT_WIN_BASE;
        3: port = PORT_WIN_STEP;
        4, 5: port = PORT_BANK_CTRL;
        6, 7: begin
          port = PORT_BANK_NUM;
          if ($urandom_range(4) != 0) data = 8'($urandom_range(EXT_BANKS - 1));
        end
        default: ;
      endcase
    end
    send_access(cmd, addr, port, data);
  endtask

  // ROM shows through while main RAM is unmapped for reads
  task automatic test_rom_passthrough();
    send_access(CMD_MEM_READ, 16'h0000, 8'h00, 8'h00);
    send_access(CMD_MEM_READ, 16'h7fff, 8'hff, 8'hff);
    send_access(CMD_MEM_WRITE, 16'h0000, 8'h00, 8'hff);
    send_access(CMD_MEM_WRITE, 16'h8000, 8'h00, 8'h5a);
    send_access(CMD_MEM_READ, 16'h8000, 8'h00, 8'h00);
    send_access(CMD_PORT_WRITE, 16'h0000, PORT_RAM_MODE, 8'hff);
    send_access(CMD_MEM_READ, 16'h0000, 8'h00, 8'h00);
  endtask

  // Window base wraps past the top of main RAM and on the step port
  task automatic test_window_mapping();
    send_access(CMD_PORT_WRITE, 16'h0000, PORT_WIN_BASE, 8'hff);
    send_access(CMD_MEM_WRITE, 16'h83ff, 8'h00, 8'ha5);
    send_access(CMD_PORT_WRITE, 16'hffff, PORT_WIN_STEP, 8'h3c);
    send_access(CMD_MEM_READ, 16'h82ff, 8'h00, 8'h00);
    send_access(CMD_MEM_READ, 16'hffff, 8'h00, 8'h00);
  endtask

  task automatic test_bank_switching();
    send_access(CMD_PORT_WRITE, 16'h0000, PORT_BANK_NUM, 8'(EXT_BANKS - 1));
    send_access(CMD_PORT_WRITE, 16'h0000, PORT_BANK_CTRL, 8'h11);
    send_access(CMD_MEM_WRITE, 16'h7fff, 8'h00, 8'h3c);
    send_access(CMD_MEM_READ, 16'h7fff, 8'h00, 8'h00);
    // Out-of-range bank falls back to main RAM
    send_access(CMD_PORT_WRITE, 16'h0000, PORT_BANK_NUM, 8'hff);
    send_access(CMD_MEM_READ, 16'h7fff, 8'h00, 8'h00);
    send_access(CMD_MEM_WRITE, 16'h1234, 8'h00, 8'h77);
    send_access(CMD_PORT_WRITE, 16'h0000, 8'h00, 8'hff);
    send_access(CMD_PORT_WRITE, 16'h0000, 8'hff, 8'h00);
  endtask

  // CPU reset clears port registers but keeps RAM and the window base
  task automatic test_cpu_reset();
    send_access(CMD_CPU_RESET, 16'hffff, 8'hff, 8'hff);
    send_access(CMD_MEM_READ, 16'h1234, 8'h00, 8'h00);
    send_access(CMD_MEM_READ, 16'h8000, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned idle_pct,
                                     int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (hot_addr[i]) hot_addr[i] = 16'($urandom_range(16'h83ff));
    repeat (count) send_random_access();
  endtask

  // Hold the receiver off while the sender keeps offering transactions
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    repeat (24) send_random_access();
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    mapper_result_t want;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rd=%h pass=%b fwd=%b", $time, out_if.read_data,
                 out_if.pass_through, out_if.forward_write);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   out_if.read_data);
          fail_count++;
        end
        if (out_if.pass_through !== want.pass_through) begin
          $display("%0t: pass_through expected %b actual %b", $time, want.pass_through,
                   out_if.pass_through);
          fail_count++;
        end
        if (out_if.forward_write !== want.forward_write) begin
          $display("%0t: forward_write expected %b actual %b", $time, want.forward_write,
                   out_if.forward_write);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count        = 0;
    quiet_cycles      = 0;
    hold_request      = 0;
    hold_left         = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_MEM_READ;
    in_if.mem_address = '0;
    in_if.port_number = '0;
    in_if.write_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Sender waits out the RAM clearing pass on in_ch.ready
    test_rom_passthrough();
    test_window_mapping();
    test_bank_switching();
    test_cpu_reset();
    test_random_traffic(125, 0, 0);
    test_random_traffic(125, 59, 0);
    test_output_backpressure();
    test_random_traffic(125, 0, 59);
    test_random_traffic(125, 12, 12);
    in_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rbw_pkg.sv
hdl/rbw_in_if.sv
hdl/rbw_out_if.sv
hdl/rbw_ctrl.sv
hdl/rbw_datapath.sv
hdl/ram_bank_window_mapper.sv
dv/tb_ram_bank_window_mapper.sv
